// File: hdl/tlmc_pkg.sv
// Package: shared types, constants and command codes of the traffic light mode controller.
`timescale 1ns / 1ps

package tlmc_pkg;

    // Widths
    localparam int COUNT_WIDTH_DEF = 21;
    localparam int TIME_W          = 20;
    localparam int BLINK_W         = 14;
    localparam int MODE_W          = 4;
    localparam int CODE_W          = 8;

    // Time limits and steps (ms)
    localparam logic [TIME_W-1:0]  TIME_MAX   = TIME_W'(1000000);
    localparam logic [TIME_W-1:0]  TIME_MIN   = TIME_W'(2000);
    localparam logic [TIME_W-1:0]  TIME_STEP  = TIME_W'(1000);
    localparam logic [BLINK_W-1:0] BLINK_MAX  = BLINK_W'(10000);
    localparam logic [BLINK_W-1:0] BLINK_MIN  = BLINK_W'(500);
    localparam logic [BLINK_W-1:0] BLINK_STEP = BLINK_W'(200);

    // Reset values
    localparam logic [TIME_W-1:0]  GREEN_RST = TIME_W'(10000);
    localparam logic [TIME_W-1:0]  RED_RST   = TIME_W'(10000);
    localparam logic [TIME_W-1:0]  AMBER_RST = TIME_W'(3000);
    localparam logic [TIME_W-1:0]  DELAY_RST = TIME_W'(10000);
    localparam logic [BLINK_W-1:0] BLINK_RST = BLINK_W'(600);

    // Command codes
    localparam logic [CODE_W-1:0] CMD_NORMAL     = 8'd10;
    localparam logic [CODE_W-1:0] CMD_OUTAGE     = 8'd20;
    localparam logic [CODE_W-1:0] CMD_CAREFUL    = 8'd30;
    localparam logic [CODE_W-1:0] CMD_TRAINS     = 8'd40;
    localparam logic [CODE_W-1:0] CMD_MAN_RED    = 8'd50;
    localparam logic [CODE_W-1:0] CMD_MAN_GREEN  = 8'd52;
    localparam logic [CODE_W-1:0] CMD_FULL_RED   = 8'd60;
    localparam logic [CODE_W-1:0] CMD_FULL_AMBER = 8'd61;
    localparam logic [CODE_W-1:0] CMD_FULL_GREEN = 8'd62;
    localparam logic [CODE_W-1:0] CMD_GREEN_DEC  = 8'd70;
    localparam logic [CODE_W-1:0] CMD_GREEN_INC  = 8'd71;
    localparam logic [CODE_W-1:0] CMD_AMBER_DEC  = 8'd72;
    localparam logic [CODE_W-1:0] CMD_AMBER_INC  = 8'd73;
    localparam logic [CODE_W-1:0] CMD_RED_DEC    = 8'd74;
    localparam logic [CODE_W-1:0] CMD_RED_INC    = 8'd75;
    localparam logic [CODE_W-1:0] CMD_BLINK_DEC  = 8'd76;
    localparam logic [CODE_W-1:0] CMD_BLINK_INC  = 8'd77;

    // Transaction kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL     = 4'd0,
        MODE_OUTAGE     = 4'd1,
        MODE_CAREFUL    = 4'd2,
        MODE_TRAINS     = 4'd3,
        MODE_MAN_RED    = 4'd4,
        MODE_MAN_GREEN  = 4'd5,
        MODE_FULL_RED   = 4'd6,
        MODE_FULL_AMBER = 4'd7,
        MODE_FULL_GREEN = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        LAMP_DARK  = 2'd0,
        LAMP_RED   = 2'd1,
        LAMP_AMBER = 2'd2,
        LAMP_GREEN = 2'd3
    } lamp_t;

    // Phase and blink times after this transaction's command
    typedef struct packed {
        logic [TIME_W-1:0]  green;
        logic [TIME_W-1:0]  amber;
        logic [TIME_W-1:0]  red;
        logic [BLINK_W-1:0] blink;
    } times_t;

    // Lamp and mode status after this transaction
    typedef struct packed {
        logic        red;
        logic        amber;
        logic        green;
        mode_t       mode;
    } status_t;

endpackage

// File: hdl/tlmc_if.sv
// Interfaces: input transaction channel and result channel with valid/ready.
`timescale 1ns / 1ps

interface tlmc_req_if
    import tlmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CODE_W-1:0] command_byte;

    modport source (output valid, output kind, output command_byte, input ready);
    modport sink   (input valid, input kind, input command_byte, output ready);
endinterface

interface tlmc_rsp_if
    import tlmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              red_lamp;
    logic              amber_lamp;
    logic              green_lamp;
    logic [MODE_W-1:0] mode_code;

    modport source (output valid, output red_lamp, output amber_lamp, output green_lamp,
                    output mode_code, input ready);
    modport sink   (input valid, input red_lamp, input amber_lamp, input green_lamp,
                    input mode_code, output ready);
endinterface

// File: hdl/tlmc_times.sv
// Phase and blink time registers with saturating adjust commands.
`timescale 1ns / 1ps

module tlmc_times
    import tlmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              kind,
    input  logic [CODE_W-1:0] command_byte,
    output times_t            times_next
);

    times_t times_reg;

    // Adjust decode; ticks leave the times alone
    always_comb
    begin
        times_next = times_reg;
        if (kind == KIND_COMMAND)
        begin
            unique case (command_byte)
                CMD_GREEN_DEC:
                    if (times_reg.green >= TIME_MIN) times_next.green = times_reg.green - TIME_STEP;
                CMD_GREEN_INC:
                    if (times_reg.green < TIME_MAX) times_next.green = times_reg.green + TIME_STEP;
                CMD_AMBER_DEC:
                    if (times_reg.amber >= TIME_MIN) times_next.amber = times_reg.amber - TIME_STEP;
                CMD_AMBER_INC:
                    if (times_reg.amber < TIME_MAX) times_next.amber = times_reg.amber + TIME_STEP;
                CMD_RED_DEC:
                    if (times_reg.red >= TIME_MIN) times_next.red = times_reg.red - TIME_STEP;
                CMD_RED_INC:
                    if (times_reg.red < TIME_MAX) times_next.red = times_reg.red + TIME_STEP;
                CMD_BLINK_DEC:
                    if (times_reg.blink >= BLINK_MIN)
                        times_next.blink = times_reg.blink - BLINK_STEP;
                CMD_BLINK_INC:
                    if (times_reg.blink < BLINK_MAX)
                        times_next.blink = times_reg.blink + BLINK_STEP;
                default: ;
            endcase
        end
    end

    // Time registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            times_reg.green <= GREEN_RST;
            times_reg.amber <= AMBER_RST;
            times_reg.red   <= RED_RST;
            times_reg.blink <= BLINK_RST;
        end
        else if (en)
        begin
            times_reg <= times_next;
        end
    end

endmodule

// File: hdl/tlmc_seq.sv
// Mode sequencer: mode entry, elapsed counter, phase stepping and blinking.
`timescale 1ns / 1ps

module tlmc_seq
    import tlmc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              kind,
    input  logic [CODE_W-1:0] command_byte,
    input  times_t            times_next,
    output status_t           status_next
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    mode_t                  mode_reg,  mode_next;
    lamp_t                  lamp_reg,  lamp_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]      delay_reg, delay_next;
    logic                   blink_reg, blink_next;

    // Intermediate values after the command or tick, before the mode runs
    mode_t                  mode_sel;
    logic                   mode_hit;
    mode_t                  mode_1;
    lamp_t                  lamp_1;
    logic [COUNT_WIDTH-1:0] elapsed_1;
    logic [TIME_W-1:0]      delay_1;
    logic                   phase_due;
    logic                   blink_due;
    logic                   do_step;
    lamp_t                  blink_lamp;

    // Mode select decode
    always_comb
    begin
        mode_hit = 1'b1;
        mode_sel = MODE_NORMAL;
        unique case (command_byte)
            CMD_NORMAL:     mode_sel = MODE_NORMAL;
            CMD_OUTAGE:     mode_sel = MODE_OUTAGE;
            CMD_CAREFUL:    mode_sel = MODE_CAREFUL;
            CMD_TRAINS:     mode_sel = MODE_TRAINS;
            CMD_MAN_RED:    mode_sel = MODE_MAN_RED;
            CMD_MAN_GREEN:  mode_sel = MODE_MAN_GREEN;
            CMD_FULL_RED:   mode_sel = MODE_FULL_RED;
            CMD_FULL_AMBER: mode_sel = MODE_FULL_AMBER;
            CMD_FULL_GREEN: mode_sel = MODE_FULL_GREEN;
            default:        mode_hit = 1'b0;
        endcase
    end

    // Tick count and mode entry action
    always_comb
    begin
        mode_1    = mode_reg;
        lamp_1    = lamp_reg;
        delay_1   = delay_reg;
        elapsed_1 = elapsed_reg;
        if (kind == KIND_TICK)
        begin
            if (elapsed_reg != COUNT_MAX) elapsed_1 = elapsed_reg + 1'b1;
        end
        else if (mode_hit && mode_sel != mode_reg)
        begin
            mode_1 = mode_sel;
            priority if (mode_sel == MODE_NORMAL)
                lamp_1 = LAMP_RED;
            else if (mode_sel == MODE_MAN_RED || mode_sel == MODE_MAN_GREEN)
                delay_1 = '0;
            else
                lamp_1 = LAMP_DARK;
        end
    end

    assign phase_due = elapsed_1 > COUNT_WIDTH'(delay_1);
    assign blink_due = elapsed_1 > COUNT_WIDTH'(times_next.blink);

    // Mode behaviour
    always_comb
    begin
        do_step      = 1'b0;
        blink_lamp   = LAMP_DARK;
        lamp_next    = lamp_1;
        delay_next   = delay_1;
        elapsed_next = elapsed_1;
        blink_next   = blink_reg;
        mode_next    = mode_1;

        unique case (mode_1)
            MODE_NORMAL:     do_step = 1'b1;
            MODE_CAREFUL:    blink_lamp = LAMP_GREEN;
            MODE_TRAINS:     blink_lamp = LAMP_RED;
            MODE_MAN_RED:    do_step = (lamp_1 != LAMP_RED);
            MODE_MAN_GREEN:  do_step = (lamp_1 != LAMP_GREEN);
            MODE_FULL_RED:   lamp_next = LAMP_RED;
            MODE_FULL_AMBER: lamp_next = LAMP_AMBER;
            MODE_FULL_GREEN: lamp_next = LAMP_GREEN;
            default:         blink_lamp = LAMP_AMBER;
        endcase

        // Phase step: red -> green -> amber -> red; dark restarts at red
        if (do_step && phase_due)
        begin
            elapsed_next = '0;
            unique case (lamp_1)
                LAMP_RED:
                begin
                    lamp_next  = LAMP_GREEN;
                    delay_next = times_next.green;
                end
                LAMP_GREEN:
                begin
                    lamp_next  = LAMP_AMBER;
                    delay_next = times_next.amber;
                end
                default:
                begin
                    lamp_next  = LAMP_RED;
                    delay_next = times_next.red;
                end
            endcase
        end

        // Blink modes: lamp lit while the blink phase is high
        if (blink_lamp != LAMP_DARK)
        begin
            if (blink_due)
            begin
                elapsed_next = '0;
                blink_next   = ~blink_reg;
            end
            lamp_next = (blink_due ? ~blink_reg : blink_reg) ? blink_lamp : LAMP_DARK;
        end
    end

    // Status for the result register
    always_comb
    begin
        status_next.red   = (lamp_next == LAMP_RED);
        status_next.amber = (lamp_next == LAMP_AMBER);
        status_next.green = (lamp_next == LAMP_GREEN);
        status_next.mode  = mode_next;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            lamp_reg    <= LAMP_RED;
            elapsed_reg <= '0;
            delay_reg   <= DELAY_RST;
            blink_reg   <= 1'b0;
        end
        else if (en)
        begin
            mode_reg    <= mode_next;
            lamp_reg    <= lamp_next;
            elapsed_reg <= elapsed_next;
            delay_reg   <= delay_next;
            blink_reg   <= blink_next;
        end
    end

endmodule

// File: hdl/traffic_light_mode_controller_core.sv
// The result of an accepted transaction is captured in the output register as it is accepted.
// Throughput: one transaction per cycle; a new one is taken while the result register
// drains, so the input stalls only while a held result is not taken.
// Reset (rst_n, async, active low): normal mode, red lit, elapsed count 0, default times,
// result register empty.
`timescale 1ns / 1ps

module traffic_light_mode_controller_core
    import tlmc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tlmc_req_if.sink   req,
    tlmc_rsp_if.source rsp
);

    logic    accept;
    times_t  times_next;
    status_t status_next;
    logic    valid_reg;
    status_t status_reg;

    // Handshake: take a transaction when the result register is free or draining
    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    tlmc_times u_times (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .kind         (req.kind),
        .command_byte (req.command_byte),
        .times_next   (times_next)
    );

    tlmc_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .kind         (req.kind),
        .command_byte (req.command_byte),
        .times_next   (times_next),
        .status_next  (status_next)
    );

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            status_reg <= status_next;
    end

    assign rsp.valid      = valid_reg;
    assign rsp.red_lamp   = status_reg.red;
    assign rsp.amber_lamp = status_reg.amber;
    assign rsp.green_lamp = status_reg.green;
    assign rsp.mode_code  = status_reg.mode;

endmodule

// File: tb/traffic_light_mode_controller_core_test.sv
// Self-checking regression for the traffic light controller: directed, limit sweep, random.
`timescale 1ns / 1ps

module traffic_light_mode_controller_core_test
    import tlmc_pkg::*;
();

    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int STALL_LIMIT = 5000;  // cycles with no transaction before giving up
    localparam int TAIL_CYCLES = 8;
    localparam int N_DIRECTED  = 25;
    localparam int N_EPISODES  = 10;    // random episodes per idling phase

    // One row of the directed table; lamp and mode only count when known is set
    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic              known;
        lamp_t             lamp;
        mode_t             mode;
    } step_row_t;

    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_TICK,    8'hFF,          1'b1, LAMP_RED,   MODE_NORMAL},
        '{KIND_TICK,    8'h00,          1'b1, LAMP_RED,   MODE_NORMAL},
        '{KIND_COMMAND, 8'h00,          1'b1, LAMP_RED,   MODE_NORMAL},
        '{KIND_COMMAND, 8'hFF,          1'b1, LAMP_RED,   MODE_NORMAL},
        '{KIND_COMMAND, CMD_NORMAL,     1'b1, LAMP_RED,   MODE_NORMAL},
        '{KIND_COMMAND, CMD_FULL_AMBER, 1'b1, LAMP_AMBER, MODE_FULL_AMBER},
        '{KIND_COMMAND, CMD_FULL_GREEN, 1'b1, LAMP_GREEN, MODE_FULL_GREEN},
        '{KIND_COMMAND, CMD_FULL_RED,   1'b1, LAMP_RED,   MODE_FULL_RED},
        '{KIND_COMMAND, CMD_FULL_RED,   1'b1, LAMP_RED,   MODE_FULL_RED},
        '{KIND_COMMAND, CMD_OUTAGE,     1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_TICK,    8'h5A,          1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_CAREFUL,    1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_TRAINS,     1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_MAN_RED,    1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_MAN_GREEN,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_MAN_RED,    1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_TICK,    8'hA5,          1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_GREEN_DEC,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_GREEN_INC,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_AMBER_DEC,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_AMBER_INC,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_RED_DEC,    1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_RED_INC,    1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_BLINK_DEC,  1'b0, LAMP_DARK,  MODE_NORMAL},
        '{KIND_COMMAND, CMD_BLINK_DEC,  1'b0, LAMP_DARK,  MODE_NORMAL}
    };

    localparam logic [CODE_W-1:0] MODE_CMDS [9] = '{
        CMD_NORMAL, CMD_OUTAGE, CMD_CAREFUL, CMD_TRAINS, CMD_MAN_RED,
        CMD_MAN_GREEN, CMD_FULL_RED, CMD_FULL_AMBER, CMD_FULL_GREEN
    };
    localparam logic [CODE_W-1:0] INC_CMDS [4] = '{
        CMD_GREEN_INC, CMD_AMBER_INC, CMD_RED_INC, CMD_BLINK_INC
    };
    localparam logic [CODE_W-1:0] DEC_CMDS [4] = '{
        CMD_GREEN_DEC, CMD_AMBER_DEC, CMD_RED_DEC, CMD_BLINK_DEC
    };

    // Idling phases: sender idle and receiver stall, percent
    localparam int PH_SEND  [4] = '{0, 59, 0, 17};
    localparam int PH_STALL [4] = '{0, 0, 59, 17};

    logic clk;
    logic rst_n;

    tlmc_req_if req_ch ();
    tlmc_rsp_if rsp_ch ();

    traffic_light_mode_controller_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted controller state, reset values
    mode_t                      ctl_mode  = MODE_NORMAL;
    lamp_t                      ctl_lamp  = LAMP_RED;
    logic [COUNT_WIDTH_DEF-1:0] ms_count  = '0;
    logic [TIME_W-1:0]          phase_ms  = DELAY_RST;
    logic                       blink_on  = 1'b0;
    logic [TIME_W-1:0]          green_ms  = GREEN_RST;
    logic [TIME_W-1:0]          amber_ms  = AMBER_RST;
    logic [TIME_W-1:0]          red_ms    = RED_RST;
    logic [BLINK_W-1:0]         blink_ms  = BLINK_RST;

    status_t lamps_expected [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_pending  = 1'b0;
    int unsigned err_count     = 0;
    int unsigned idle_cycles   = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic status_t lamp_status(input lamp_t l, input mode_t m);
        status_t s;
        s.red   = (l == LAMP_RED);
        s.amber = (l == LAMP_AMBER);
        s.green = (l == LAMP_GREEN);
        s.mode  = m;
        return s;
    endfunction

    // Cycle red -> green -> amber -> red once the current phase has run out
    function automatic void cycle_step();
        if (ms_count > phase_ms)
        begin
            ms_count = '0;
            case (ctl_lamp)
                LAMP_RED:
                begin
                    ctl_lamp = LAMP_GREEN;
                    phase_ms = green_ms;
                end
                LAMP_GREEN:
                begin
                    ctl_lamp = LAMP_AMBER;
                    phase_ms = amber_ms;
                end
                default:    // amber, or dark: restart at red
                begin
                    ctl_lamp = LAMP_RED;
                    phase_ms = red_ms;
                end
            endcase
        end
    endfunction

    // Toggle the blink phase on time-out; lamp lit while the phase is high
    function automatic void blink_step(input lamp_t l);
        if (ms_count > blink_ms)
        begin
            ms_count = '0;
            blink_on = ~blink_on;
        end
        ctl_lamp = blink_on ? l : LAMP_DARK;
    endfunction

    // Mode change with its entry action; reselecting the same mode does nothing
    function automatic void select_mode(input mode_t m);
        if (m != ctl_mode)
        begin
            ctl_mode = m;
            if (m == MODE_NORMAL)
                ctl_lamp = LAMP_RED;
            else if (m == MODE_MAN_RED || m == MODE_MAN_GREEN)
                phase_ms = '0;
            else
                ctl_lamp = LAMP_DARK;
        end
    endfunction

    // Lamps and mode after one tick or command
    function automatic status_t predict_lamps(input logic k, input logic [CODE_W-1:0] c);
        if (k == KIND_COMMAND)
        begin
            case (c)
                CMD_NORMAL:     select_mode(MODE_NORMAL);
                CMD_OUTAGE:     select_mode(MODE_OUTAGE);
                CMD_CAREFUL:    select_mode(MODE_CAREFUL);
                CMD_TRAINS:     select_mode(MODE_TRAINS);
                CMD_MAN_RED:    select_mode(MODE_MAN_RED);
                CMD_MAN_GREEN:  select_mode(MODE_MAN_GREEN);
                CMD_FULL_RED:   select_mode(MODE_FULL_RED);
                CMD_FULL_AMBER: select_mode(MODE_FULL_AMBER);
                CMD_FULL_GREEN: select_mode(MODE_FULL_GREEN);
                CMD_GREEN_DEC:  if (green_ms >= TIME_MIN) green_ms -= TIME_STEP;
                CMD_GREEN_INC:  if (green_ms < TIME_MAX) green_ms += TIME_STEP;
                CMD_AMBER_DEC:  if (amber_ms >= TIME_MIN) amber_ms -= TIME_STEP;
                CMD_AMBER_INC:  if (amber_ms < TIME_MAX) amber_ms += TIME_STEP;
                CMD_RED_DEC:    if (red_ms >= TIME_MIN) red_ms -= TIME_STEP;
                CMD_RED_INC:    if (red_ms < TIME_MAX) red_ms += TIME_STEP;
                CMD_BLINK_DEC:  if (blink_ms >= BLINK_MIN) blink_ms -= BLINK_STEP;
                CMD_BLINK_INC:  if (blink_ms < BLINK_MAX) blink_ms += BLINK_STEP;
                default: ;
            endcase
        end
        else if (ms_count != '1)
            ms_count = ms_count + 1'b1;

        case (ctl_mode)
            MODE_NORMAL:     cycle_step();
            MODE_CAREFUL:    blink_step(LAMP_GREEN);
            MODE_TRAINS:     blink_step(LAMP_RED);
            MODE_MAN_RED:    if (ctl_lamp != LAMP_RED) cycle_step();
            MODE_MAN_GREEN:  if (ctl_lamp != LAMP_GREEN) cycle_step();
            MODE_FULL_RED:   ctl_lamp = LAMP_RED;
            MODE_FULL_AMBER: ctl_lamp = LAMP_AMBER;
            MODE_FULL_GREEN: ctl_lamp = LAMP_GREEN;
            default:         blink_step(LAMP_AMBER);
        endcase
        return lamp_status(ctl_lamp, ctl_mode);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Offer one transaction from a falling edge; returns at the falling edge after acceptance.
    // valid is left high so that a following transaction can go back to back.
    task automatic send_item(input logic k, input logic [CODE_W-1:0] c,
                             input logic typed = 1'b0, input status_t typed_want = '0);
        status_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= k;
        req_ch.command_byte <= c;
        do @(posedge clk); while (!req_ch.ready);
        s = predict_lamps(k, c);
        lamps_expected.push_back(typed ? typed_want : s);
        @(negedge clk);
    endtask

    // Sender pause until every predicted result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (lamps_expected.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (lamps_expected.size() == 0)
                flag_error("result with no transaction outstanding");
            else
            begin
                want = lamps_expected.pop_front();
                if (rsp_ch.red_lamp !== want.red || rsp_ch.amber_lamp !== want.amber ||
                    rsp_ch.green_lamp !== want.green || rsp_ch.mode_code !== want.mode)
                    flag_error($sformatf("got r%b a%b g%b mode %0d, want r%b a%b g%b mode %0d",
                        rsp_ch.red_lamp, rsp_ch.amber_lamp, rsp_ch.green_lamp,
                        rsp_ch.mode_code, want.red, want.amber, want.green, want.mode));
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("traffic_light_mode_controller_core regression: fail");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned        roll;
        int unsigned        n;
        logic [CODE_W-1:0]  c;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_TICK;
        req_ch.command_byte = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: extremes, every code but blink increase, blink and manual entry cases
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].kind, DIRECTED[i].code, DIRECTED[i].known,
                      lamp_status(DIRECTED[i].lamp, DIRECTED[i].mode));

        // Every time down past its floor, then the blink time up past its ceiling and back
        for (int t = 0; t < 4; t++)
            repeat (12) send_item(KIND_COMMAND, DEC_CMDS[t]);
        repeat (50) send_item(KIND_COMMAND, CMD_BLINK_INC);
        repeat (50) send_item(KIND_COMMAND, CMD_BLINK_DEC);
        wait_drained();

        // Random traffic over the idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = PH_SEND[ph];
            stall_pct     = PH_STALL[ph];

            // Long receiver hold-off while ticks keep coming: the input must back up
            if (ph == 0)
            begin
                hold_pending = 1'b1;
                repeat (24) send_item(KIND_TICK, 8'($urandom));
                wait_drained();
            end

            for (int e = 0; e < N_EPISODES; e++)
            begin
                roll = $urandom_range(99);
                if (roll < 35)
                begin
                    // tick run, now and then a longer one
                    n = ($urandom_range(99) < 15) ? $urandom_range(60, 20)
                                                  : $urandom_range(12, 1);
                    repeat (n) send_item(KIND_TICK, 8'($urandom));
                end
                else if (roll < 55)
                    send_item(KIND_COMMAND, MODE_CMDS[$urandom_range(8)]);
                else if (roll < 80)
                begin
                    // biased towards shorter times so the cycle keeps turning
                    if ($urandom_range(3) == 0)
                        send_item(KIND_COMMAND, INC_CMDS[$urandom_range(3)]);
                    else
                        send_item(KIND_COMMAND, DEC_CMDS[$urandom_range(3)]);
                end
                else if (roll < 92)
                    send_item(KIND_COMMAND, 8'($urandom));
                else
                begin
                    // same mode picked twice in a row
                    c = MODE_CMDS[$urandom_range(8)];
                    send_item(KIND_COMMAND, c);
                    send_item(KIND_COMMAND, c);
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (lamps_expected.size() != 0)
            flag_error($sformatf("%0d results never arrived", lamps_expected.size()));

        if (err_count == 0)
            $display("traffic_light_mode_controller_core regression: pass");
        else
            $display("traffic_light_mode_controller_core regression: fail");
        $finish;
    end

endmodule

// File: traffic_light_mode_controller_core.f
hdl/tlmc_pkg.sv
hdl/tlmc_if.sv
hdl/tlmc_times.sv
hdl/tlmc_seq.sv
hdl/traffic_light_mode_controller_core.sv
tb/traffic_light_mode_controller_core_test.sv
